// ===== hdl/multi_level_priority_queue_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the multilevel priority queue
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MLPQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlpq assertion failed");

// antecedent implies consequent in the next cycle
`define MLPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlpq assertion failed");

`endif

// ===== hdl/mlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpq_pkg
// Shared types and codes of the multilevel priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpq_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    localparam logic SCAN_ASCENDING  = 1'b0;
    localparam logic SCAN_DESCENDING = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_INVALID  = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/mlpq_ifs.sv =====
// ----------------------------------------------------------------------------
// mlpq channel interfaces
// Command channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlpq_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [3:0]         priority_req;
    logic signed [31:0] data_in;
    logic               scan_order;

    modport source (output valid, cmd, priority_req, data_in, scan_order, input ready);
    modport sink   (input valid, cmd, priority_req, data_in, scan_order, output ready);
endinterface

interface mlpq_out_if import mlpq_pkg::*; ();
    logic               valid;
    logic               ready;
    t_status            status;
    logic signed [31:0] data_out;
    logic [3:0]         level_out;

    modport source (output valid, status, data_out, level_out, input ready);
    modport sink   (input valid, status, data_out, level_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/mlpq_ram.sv =====
// ----------------------------------------------------------------------------
// mlpq_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/multi_level_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// multi_level_priority_queue_top
// One bounded ring FIFO per priority level, entries held in a shared RAM.
//
// Channels: i_in carries commands (insert at priority_req, or delete by
// scan_order), o_out carries one result per command. Both are valid/ready;
// a transfer happens when both are high at a rising edge.
// Results: an insert, invalid, full or empty result is registered and valid in
// the cycle after the command transfer. A delete reads the head entry from
// the RAM, whose read port is registered, so its result passes the S_READ
// state and then the output register. Commands: one command per cycle while
// ready is high; ready drops during S_READ. Non-empty levels are picked by a
// priority encoder over per-level counts kept in flip-flops.
// Reset: synchronous, active low; all levels become empty at once, no
// clearing pass. The entry RAM is not cleared.
// Stall: the result sits in an output register; a new command is taken
// while that register is empty or being drained in the same cycle, outside S_READ.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_level_priority_queue_top import mlpq_pkg::*; #(
    parameter int NUM_LEVELS  = 4,
    parameter int LEVEL_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mlpq_in_if.sink    i_in,
    mlpq_out_if.source o_out
);

    localparam int LVL_W  = $clog2(NUM_LEVELS);
    localparam int PTR_W  = $clog2(LEVEL_DEPTH);
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int SUM_W  = PTR_W + 1;
    localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);

    t_state             r_state, n_state;
    logic               r_out_valid, n_out_valid;
    t_status            r_status, n_status;
    logic signed [31:0] r_data, n_data;
    logic [3:0]         r_level, n_level;
    logic [PTR_W-1:0]   r_head [NUM_LEVELS];
    logic [PTR_W-1:0]   n_head [NUM_LEVELS];
    logic [CNT_W-1:0]   r_count [NUM_LEVELS];
    logic [CNT_W-1:0]   n_count [NUM_LEVELS];

    logic               in_fire;
    logic [LVL_W-1:0]   ins_lvl;
    logic               ins_invalid;
    logic               ins_full;
    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail_ptr;
    logic               found;
    logic [LVL_W-1:0]   sel_lvl;
    logic [PTR_W-1:0]   sel_head_next;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [31:0]        ram_rdata;

    mlpq_ram #(
        .WIDTH (32),
        .DEPTH (NUM_LEVELS * LEVEL_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ($unsigned(i_in.data_in)),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_in.ready     = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_fire        = i_in.valid && i_in.ready;
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_status;
    assign o_out.data_out = r_data;
    assign o_out.level_out = r_level;

    assign ins_lvl     = i_in.priority_req[LVL_W-1:0];
    assign ins_invalid = {1'b0, i_in.priority_req} >= 5'(NUM_LEVELS);

    always_comb begin
        ins_full = 1'b0;
        tail_sum = '0;
        if (!ins_invalid) begin
            ins_full = r_count[ins_lvl] == CNT_W'(LEVEL_DEPTH);
            tail_sum = SUM_W'(r_head[ins_lvl]) + SUM_W'(r_count[ins_lvl]);
        end
        if (tail_sum >= SUM_W'(LEVEL_DEPTH)) begin
            tail_ptr = PTR_W'(tail_sum - SUM_W'(LEVEL_DEPTH));
        end else begin
            tail_ptr = PTR_W'(tail_sum);
        end
    end

    // first non-empty level in scan order; the last hit in the loop wins
    always_comb begin
        found   = 1'b0;
        sel_lvl = '0;
        if (i_in.scan_order == SCAN_DESCENDING) begin
            for (int k = 0; k < NUM_LEVELS; k++) begin
                if (r_count[k] != '0) begin
                    found   = 1'b1;
                    sel_lvl = LVL_W'(k);
                end
            end
        end else begin
            for (int k = NUM_LEVELS - 1; k >= 0; k--) begin
                if (r_count[k] != '0) begin
                    found   = 1'b1;
                    sel_lvl = LVL_W'(k);
                end
            end
        end
    end

    assign sel_head_next = (r_head[sel_lvl] == PTR_W'(LEVEL_DEPTH - 1)) ? '0
                         : r_head[sel_lvl] + PTR_W'(1);

    assign ram_waddr = ADDR_W'(ins_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(tail_ptr);
    assign ram_raddr = ADDR_W'(sel_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(r_head[sel_lvl]);
    assign ram_we    = in_fire && (i_in.cmd == CMD_INSERT) && !ins_invalid && !ins_full;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_data      = r_data;
        n_level     = r_level;
        n_head      = r_head;
        n_count     = r_count;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_data  = '0;
                    n_level = '0;
                    if (i_in.cmd == CMD_INSERT) begin
                        n_out_valid = 1'b1;
                        if (ins_invalid) begin
                            n_status = ST_INVALID;
                        end else if (ins_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_status         = ST_INSERTED;
                            n_level          = 4'(ins_lvl);
                            n_count[ins_lvl] = r_count[ins_lvl] + CNT_W'(1);
                        end
                    end else if (!found) begin
                        n_out_valid = 1'b1;
                        n_status    = ST_EMPTY;
                    end else begin
                        n_state          = S_READ;
                        n_level          = 4'(sel_lvl);
                        n_head[sel_lvl]  = sel_head_next;
                        n_count[sel_lvl] = r_count[sel_lvl] - CNT_W'(1);
                    end
                end
            end
            S_READ: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
                n_status    = ST_REMOVED;
                n_data      = $signed(ram_rdata);
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_LEVELS; k++) begin
                r_head[k]  <= '0;
                r_count[k] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_data   <= n_data;
        r_level  <= n_level;
    end

endmodule

`default_nettype wire

// ===== hdl/mlpq_checker.sv =====
// ----------------------------------------------------------------------------
// mlpq_checker
// Port-level checks of the multilevel priority queue, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_level_priority_queue_top_assert.svh"

module mlpq_checker import mlpq_pkg::*; #(
    parameter int NUM_LEVELS = 4
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_in_cmd,
    input wire logic [3:0]  i_in_priority_req,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  i_out_status,
    input wire logic [31:0] i_out_data_out,
    input wire logic [3:0]  i_out_level_out
);

    logic        in_xfer;
    logic        bad_insert;
    logic        no_level;
    logic        out_stall;
    logic        out_not_removed;
    logic        out_invalid;
    logic [38:0] out_payload;

    assign in_xfer    = i_in_valid && i_in_ready;
    assign bad_insert = in_xfer && (i_in_cmd == CMD_INSERT)
                      && ({1'b0, i_in_priority_req} >= 5'(NUM_LEVELS));
    assign no_level   = (i_out_status == ST_INVALID) || (i_out_status == ST_EMPTY)
                      || (i_out_status == ST_FULL);

    assign out_stall       = i_out_valid && !i_out_ready;
    assign out_not_removed = i_out_valid && (i_out_status != ST_REMOVED);
    assign out_invalid     = i_out_valid && (i_out_status == ST_INVALID);
    assign out_payload     = {i_out_status, i_out_data_out, i_out_level_out};

    `MLPQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_payload))
    `MLPQ_ASSERT_NOW(a_data_zero, i_clk, i_rst_n, out_not_removed, i_out_data_out == '0)
    `MLPQ_ASSERT_NOW(a_level_zero, i_clk, i_rst_n, i_out_valid && no_level, i_out_level_out == '0)
    `MLPQ_ASSERT_NEXT(a_invalid_prio, i_clk, i_rst_n, bad_insert, out_invalid)

endmodule

bind multi_level_priority_queue_top mlpq_checker #(
    .NUM_LEVELS (NUM_LEVELS)
) u_mlpq_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_in_cmd          (i_in.cmd),
    .i_in_priority_req (i_in.priority_req),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_status      (o_out.status),
    .i_out_data_out    (o_out.data_out),
    .i_out_level_out   (o_out.level_out)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: multilevel priority queue testbench
// Drives inserts and deletes into multi_level_priority_queue_top over the
// command channel and mirrors the per-level ring FIFOs in a small class.
// Each result transfer is checked field by field against the oldest
// predicted result. A directed opening covers the empty, invalid and full
// cases and the value extremes. Random phases follow, biased to fill or
// drain the levels, with random idling on both sides, two idle-free
// stretches, and one long result hold-off that backs the block up.
// ----------------------------------------------------------------------------

module tb_top import mlpq_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_LEVELS   = 4;
    localparam int LEVEL_DEPTH  = 16;
    localparam int PHASE_ITEMS  = 250;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        t_status     status;
        logic [31:0] data;
        logic [3:0]  level;
    } t_queue_result;

    class level_fifo_mirror #(int LEVELS = 4, int DEPTH = 16);
        logic [31:0]   ring [LEVELS][DEPTH];
        int            head [LEVELS];
        int            fill [LEVELS];
        t_queue_result pending_results [$];
        int            mismatches;
        int            commands;
        int            status_seen [5];

        function new();
            for (int l = 0; l < LEVELS; l++) begin
                head[l] = 0;
                fill[l] = 0;
            end
            for (int s = 0; s < 5; s++) begin
                status_seen[s] = 0;
            end
            mismatches = 0;
            commands   = 0;
        endfunction

        function void apply_command(logic cmd, logic [3:0] prio, logic [31:0] data,
                                    logic scan);
            t_queue_result r;
            int            lvl;
            int            slot;
            r.status = ST_EMPTY;
            r.data   = '0;
            r.level  = '0;
            commands++;
            if (cmd == CMD_INSERT) begin
                lvl = int'(prio);
                if (lvl >= LEVELS) begin
                    r.status = ST_INVALID;
                end else if (fill[lvl] == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    slot = (head[lvl] + fill[lvl]) % DEPTH;
                    ring[lvl][slot] = data;
                    fill[lvl]++;
                    r.status = ST_INSERTED;
                    r.level  = prio;
                end
            end else begin
                for (int k = 0; k < LEVELS; k++) begin
                    lvl = (scan == SCAN_DESCENDING) ? LEVELS - 1 - k : k;
                    if (r.status == ST_EMPTY && fill[lvl] != 0) begin
                        r.status  = ST_REMOVED;
                        r.data    = ring[lvl][head[lvl]];
                        r.level   = 4'(lvl);
                        head[lvl] = (head[lvl] + 1) % DEPTH;
                        fill[lvl]--;
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(t_status st, logic [31:0] data, logic [3:0] level);
            t_queue_result e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with none due: status %0d data %h level %0d",
                             $realtime, st, data, level);
            end else begin
                e = pending_results.pop_front();
                status_seen[int'(e.status)]++;
                if (st !== e.status || data !== e.data || level !== e.level) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: mismatch: expected status %0d data %h level %0d",
                                 $realtime, e.status, e.data, e.level);
                        $display("%0t: mismatch: got      status %0d data %h level %0d",
                                 $realtime, st, data, level);
                    end
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mlpq_in_if  in_ch ();
    mlpq_out_if out_ch ();

    multi_level_priority_queue_top #(
        .NUM_LEVELS  (NUM_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    level_fifo_mirror #(NUM_LEVELS, LEVEL_DEPTH) levels;

    bit sender_idle;
    bit receiver_idle;
    int hold_request;
    int timeout_cycles;

    always #4 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_command(input logic cmd, input logic [3:0] prio,
                                input logic [31:0] data, input logic scan);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.cmd          <= cmd;
        in_ch.priority_req <= prio;
        in_ch.data_in      <= data;
        in_ch.scan_order   <= scan;
        do @(posedge i_clk); while (!in_ch.ready);
        levels.apply_command(cmd, prio, data, scan);
        @(negedge i_clk);
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic insert_item(input logic [3:0] prio, input logic [31:0] data);
        send_command(CMD_INSERT, prio, data, 1'($urandom_range(1)));
    endtask

    task automatic remove_item(input logic scan);
        send_command(CMD_DELETE, 4'($urandom()), $urandom(), scan);
    endtask

    task automatic send_random(input int insert_pct);
        logic [3:0]  prio;
        logic [31:0] data;
        int          r;
        if ($urandom_range(99) < insert_pct) begin
            r = $urandom_range(99);
            prio = (r < 90) ? 4'($urandom_range(NUM_LEVELS - 1))
                            : 4'($urandom_range(15, NUM_LEVELS));
            r = $urandom_range(9);
            data = (r == 0) ? 32'h8000_0000 : (r == 1) ? 32'h7FFF_FFFF : $urandom();
            insert_item(prio, data);
        end else begin
            remove_item(1'($urandom_range(1)));
        end
    endtask

    task automatic wait_drained();
        if (in_ch.valid)
            in_ch.valid <= 1'b0;
        while (levels.pending_results.size() != 0) @(negedge i_clk);
    endtask

    // result sink: ready changes at the falling edge only
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
                if (receiver_idle)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            levels.check_result(out_ch.status, out_ch.data_out, out_ch.level_out);
    end

    initial begin : watchdog
        for (timeout_cycles = 0; timeout_cycles < CYCLE_LIMIT; timeout_cycles++)
            @(posedge i_clk);
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        int insert_mix [8];
        int top;
        insert_mix = '{85, 15, 50, 60, 90, 10, 50, 35};
        top = NUM_LEVELS - 1;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.cmd          <= CMD_INSERT;
        in_ch.priority_req <= '0;
        in_ch.data_in      <= '0;
        in_ch.scan_order   <= SCAN_ASCENDING;
        sender_idle   = 1'b0;
        receiver_idle = 1'b0;
        hold_request  = 0;
        levels = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // all levels empty, both scan orders
        remove_item(SCAN_ASCENDING);
        remove_item(SCAN_DESCENDING);
        // invalid priorities, highest code and first one past the top level
        insert_item(4'd15, 32'h1234_5678);
        insert_item(4'(NUM_LEVELS), 32'hFFFF_FFFF);
        // fill the top level, extremes at head and tail, then one more
        insert_item(4'(top), 32'h8000_0000);
        for (int i = 0; i < LEVEL_DEPTH - 2; i++)
            insert_item(4'(top), $urandom());
        insert_item(4'(top), 32'h7FFF_FFFF);
        insert_item(4'(top), 32'h0000_0000);
        insert_item(4'd0, 32'hFFFF_FFFF);
        insert_item(4'd1, 32'h0000_0000);
        remove_item(SCAN_DESCENDING);
        remove_item(SCAN_ASCENDING);
        remove_item(SCAN_ASCENDING);
        wait_drained();

        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        for (int phase = 0; phase < 8; phase++) begin
            sender_idle   = (phase != 2 && phase != 3 && phase != 6);
            receiver_idle = (phase != 2 && phase != 6);
            // long result hold-off while commands keep coming
            if (phase == 3)
                hold_request = 150;
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random(insert_mix[phase]);
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        $display("covered %0d commands: %0d inserted, %0d removed, %0d invalid,",
                 levels.commands, levels.status_seen[int'(ST_INSERTED)],
                 levels.status_seen[int'(ST_REMOVED)], levels.status_seen[int'(ST_INVALID)]);
        $display("%0d empty, %0d full; %0d mismatches, %0d results never arrived, %0d cycles",
                 levels.status_seen[int'(ST_EMPTY)], levels.status_seen[int'(ST_FULL)],
                 levels.mismatches, levels.pending_results.size(), timeout_cycles);
        if (levels.mismatches == 0 && levels.pending_results.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/mlpq_pkg.sv
hdl/mlpq_ifs.sv
hdl/mlpq_ram.sv
hdl/multi_level_priority_queue_top.sv
hdl/mlpq_checker.sv
dv/tb_top.sv
